// ===== rtl/rgbe_pkg.sv =====
// Shared constants and types for the RGB 3x3 edge threshold block.
package rgbe_pkg;

  // Width of the internal domain used to compare counters against dimensions.
  localparam int DIM_W   = 14;
  localparam int CHAN_W  = 8;
  localparam int MIN_DIM = 3;

  // Sum of one channel: 4*center minus four neighbors, plus room for the compare.
  localparam int SUM_W = CHAN_W + 4;

  localparam logic [CHAN_W-1:0] COLOR_EDGE = 8'd0;
  localparam logic [CHAN_W-1:0] COLOR_FLAT = 8'd255;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_idx_t;

endpackage

// ===== rtl/rgbe_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module rgbe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/rgb_edge_threshold_3x3.sv =====
// Top level of the streaming RGB 3x3 diagonal Laplacian edge marker.
//
// Pixels come in raster order on the pixel channel (pix_valid, pix_stall), one
// word per pixel with red, green, blue and a frame_start flag on the first
// pixel of a frame. For every interior pixel the block sends one word on the
// result channel (res_valid, res_stall): the row and column of the judged
// pixel, a color of 0 for an edge or 255 otherwise, and frame_end on the last
// interior pixel. Border pixels produce no word.
// The line stores are read in the cycle a pixel is accepted, the kernel and
// threshold run in the next cycle, and the result register drives the outputs
// once the kernel stage fires. Throughput is one pixel per cycle unless the
// result channel stalls; the two line store RAMs take one read and one write
// each per cycle. A pixel is accepted while an earlier result still waits in
// the result register; only when that register and the kernel stage are both
// full and res_stall is high does pix_stall rise. Reset clears the counters,
// the window registers, the configuration (threshold 0, width and height 1024)
// and empties the pipeline; the line stores are not cleared. Configuration is
// written through cfg_valid/cfg_ready, which is always ready.
module rgb_edge_threshold_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int CHANNELS   = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  // Pixel channel.
  input  logic                            pix_valid,
  output logic                            pix_stall,
  input  logic [7:0]                      red,
  input  logic [7:0]                      green,
  input  logic [7:0]                      blue,
  input  logic                            frame_start,
  // Result channel.
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [9:0]                      out_row,
  output logic [9:0]                      out_col,
  output logic [7:0]                      out_color,
  output logic                            frame_end,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rgbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [10:0]                     cfg_data
);

  localparam int DW    = rgbe_pkg::DIM_W;
  localparam int CHW   = rgbe_pkg::CHAN_W;
  localparam int SW    = rgbe_pkg::SUM_W;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  // At most three channels are used; a CHANNELS value above three acts as three.
  localparam int USED  = (CHANNELS < 3) ? CHANNELS : 3;
  localparam int PXW   = USED * CHW;

  // Configuration registers.
  logic [9:0]  edge_threshold;
  logic [10:0] image_width;
  logic [10:0] image_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= '0;
      image_width    <= 11'd1024;
      image_height   <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rgbe_pkg::CFG_THRESHOLD: edge_threshold <= cfg_data[9:0];
        rgbe_pkg::CFG_WIDTH:     image_width    <= cfg_data;
        rgbe_pkg::CFG_HEIGHT:    image_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective dimensions: below three acts as three, above the maximum as the maximum.
  logic [DW-1:0] width_raw, height_raw, width_eff, height_eff;

  assign width_raw  = DW'(image_width);
  assign height_raw = DW'(image_height);

  always_comb begin
    if (width_raw < DW'(rgbe_pkg::MIN_DIM)) begin
      width_eff = DW'(rgbe_pkg::MIN_DIM);
    end else if (width_raw > DW'(MAX_WIDTH)) begin
      width_eff = DW'(MAX_WIDTH);
    end else begin
      width_eff = width_raw;
    end
    if (height_raw < DW'(rgbe_pkg::MIN_DIM)) begin
      height_eff = DW'(rgbe_pkg::MIN_DIM);
    end else if (height_raw > DW'(MAX_HEIGHT)) begin
      height_eff = DW'(MAX_HEIGHT);
    end else begin
      height_eff = height_raw;
    end
  end

  // Handshakes.
  logic s1_valid;
  logic s1_fire;
  logic pix_accept;

  assign s1_fire    = s1_valid && (!res_valid || !res_stall);
  assign pix_stall  = s1_valid && !s1_fire;
  assign pix_accept = pix_valid && !pix_stall;

  // Pack the supplied channels into one pixel word.
  logic [2:0][CHW-1:0] in_chan;
  logic [PXW-1:0]      px_in;

  assign in_chan = {blue, green, red};

  always_comb begin
    for (int k = 0; k < USED; k++) begin
      px_in[k*CHW +: CHW] = in_chan[k];
    end
  end

  // Position counters. The position of the accepted pixel is settled first:
  // frame_start restarts the frame, and a count left past a shrunk dimension wraps.
  logic [CW-1:0] col_count, col_next, col_cur;
  logic [RW-1:0] row_count, row_next, row_cur;
  logic [CW-1:0] col_base;
  logic [RW-1:0] row_base;
  logic [DW-1:0] row_step, col_inc, row_inc;

  always_comb begin
    col_base = frame_start ? '0 : col_count;
    row_base = frame_start ? '0 : row_count;

    if (DW'(col_base) >= width_eff) begin
      col_cur  = '0;
      row_step = DW'(row_base) + DW'(1);
    end else begin
      col_cur  = col_base;
      row_step = DW'(row_base);
    end
    row_cur = (row_step >= height_eff) ? '0 : row_step[RW-1:0];

    col_inc = DW'(col_cur) + DW'(1);
    row_inc = DW'(row_cur) + DW'(1);
    if (col_inc >= width_eff) begin
      col_next = '0;
      row_next = (row_inc >= height_eff) ? '0 : row_inc[RW-1:0];
    end else begin
      col_next = col_inc[CW-1:0];
      row_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (pix_accept) begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

  // Kernel stage registers.
  logic [PXW-1:0] s1_px;
  logic [CW-1:0]  s1_col;
  logic [RW-1:0]  s1_row;

  // Line stores: read at the new pixel's column, written when the kernel stage fires.
  logic [PXW-1:0] up_q, mid_q, up_px, mid_px;
  logic           bypass;
  logic [PXW-1:0] bypass_up, bypass_mid;

  rgbe_ram #(.WIDTH(PXW), .DEPTH(MAX_WIDTH)) u_line_upper (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_col),
    .wr_data (mid_px),
    .rd_en   (pix_accept),
    .rd_addr (col_cur),
    .rd_data (up_q)
  );

  rgbe_ram #(.WIDTH(PXW), .DEPTH(MAX_WIDTH)) u_line_middle (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_col),
    .wr_data (s1_px),
    .rd_en   (pix_accept),
    .rd_addr (col_cur),
    .rd_data (mid_q)
  );

  // Two back-to-back pixels at the same column (repeated frame starts) would
  // read a line store entry in the cycle it is written, so that data is forwarded.
  always_ff @(posedge clk) begin
    if (pix_accept) begin
      bypass_up  <= mid_px;
      bypass_mid <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass <= 1'b0;
    end else if (pix_accept) begin
      bypass <= s1_fire && (s1_col == col_cur);
    end
  end

  assign up_px  = bypass ? bypass_up  : up_q;
  assign mid_px = bypass ? bypass_mid : mid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_px  <= px_in;
      s1_col <= col_cur;
      s1_row <= row_cur;
    end
  end

  // Window registers: two earlier columns of the upper row, one of the middle
  // row and two of the current row.
  logic [PXW-1:0] win_up1, win_up2, win_mid1, win_cur1, win_cur2;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_up1  <= '0;
      win_up2  <= '0;
      win_mid1 <= '0;
      win_cur1 <= '0;
      win_cur2 <= '0;
    end else if (s1_fire) begin
      win_up2  <= win_up1;
      win_up1  <= up_px;
      win_mid1 <= mid_px;
      win_cur2 <= win_cur1;
      win_cur1 <= s1_px;
    end
  end

  // Kernel: the center is the middle row one column back; the diagonal
  // neighbors are the upper and current rows two columns back and at this column.
  logic                 is_edge;
  logic signed [SW-1:0] chan_sum;

  always_comb begin
    is_edge  = 1'b0;
    chan_sum = '0;
    for (int k = 0; k < USED; k++) begin
      chan_sum = $signed({2'b00, win_mid1[k*CHW +: CHW], 2'b00})
               - $signed(SW'(win_up2[k*CHW +: CHW]))
               - $signed(SW'(up_px[k*CHW +: CHW]))
               - $signed(SW'(win_cur2[k*CHW +: CHW]))
               - $signed(SW'(s1_px[k*CHW +: CHW]));
      if (chan_sum > $signed(SW'(edge_threshold))) begin
        is_edge = 1'b1;
      end
    end
  end

  logic          has_result;
  logic          last_interior;
  logic [RW-1:0] row_judged;
  logic [CW-1:0] col_judged;

  assign has_result    = (DW'(s1_row) >= DW'(2)) && (DW'(s1_col) >= DW'(2));
  assign last_interior = (DW'(s1_row) == height_eff - DW'(1)) &&
                         (DW'(s1_col) == width_eff - DW'(1));
  assign row_judged    = s1_row - RW'(1);
  assign col_judged    = s1_col - CW'(1);

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire) begin
      res_valid <= has_result;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_row   <= 10'(row_judged);
      out_col   <= 10'(col_judged);
      out_color <= is_edge ? rgbe_pkg::COLOR_EDGE : rgbe_pkg::COLOR_FLAT;
      frame_end <= last_interior;
    end
  end

endmodule
